/* hw/rtl/ppmfe_pkg.sv */
// shared types, widths and constants of the ppm frame encoder
package ppmfe_pkg;

    localparam int IDX_W     = 4;
    localparam int VAL_W     = 15;
    localparam int TICK_W    = 16;
    localparam int PHASE_W   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 15;
    localparam int STORE_DEPTH = 16;
    // |value| <= 2^14 and scale <= 1023, so the product stays below 2^24
    localparam int PROD_W    = 24;
    localparam int US_W      = 27;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_SCALE  = 3'd0,
        CFG_CENTRE_WIDTH = 3'd1,
        CFG_CHANNEL_SYNC = 3'd2,
        CFG_FRAME_SYNC   = 3'd3,
        CFG_IDLE_HIGH    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [9:0]  pulse_scale_us;
        logic [11:0] centre_width_us;
        logic [9:0]  channel_sync_us;
        logic [14:0] frame_sync_us;
        logic        idle_high;
    } cfg_t;

    localparam logic [9:0]  RST_PULSE_SCALE  = 10'd500;
    localparam logic [11:0] RST_CENTRE_WIDTH = 12'd1500;
    localparam logic [9:0]  RST_CHANNEL_SYNC = 10'd300;
    localparam logic [14:0] RST_FRAME_SYNC   = 15'd6000;
    localparam logic        RST_IDLE_HIGH    = 1'b1;

    typedef enum logic [1:0] {
        KIND_FRAME = 2'd0,
        KIND_SYNC  = 2'd1,
        KIND_CHAN  = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [PHASE_W-1:0] phase;
    } ctl_t;

    typedef struct packed {
        ctl_t                    ctl;
        logic signed [VAL_W-1:0] value;
    } ev_t;

endpackage

/* hw/rtl/ppmfe_cfg_regs.sv */
// configuration register bank of the ppm frame encoder
module ppmfe_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ppmfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ppmfe_pkg::CFG_DAT_W-1:0] cfg_wdata,
    output ppmfe_pkg::cfg_t                cfg
);
    import ppmfe_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_scale_us  <= RST_PULSE_SCALE;
            cfg_reg.centre_width_us <= RST_CENTRE_WIDTH;
            cfg_reg.channel_sync_us <= RST_CHANNEL_SYNC;
            cfg_reg.frame_sync_us   <= RST_FRAME_SYNC;
            cfg_reg.idle_high       <= RST_IDLE_HIGH;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PULSE_SCALE:  cfg_reg.pulse_scale_us  <= cfg_wdata[9:0];
                CFG_CENTRE_WIDTH: cfg_reg.centre_width_us <= cfg_wdata[11:0];
                CFG_CHANNEL_SYNC: cfg_reg.channel_sync_us <= cfg_wdata[9:0];
                CFG_FRAME_SYNC:   cfg_reg.frame_sync_us   <= cfg_wdata[14:0];
                CFG_IDLE_HIGH:    cfg_reg.idle_high       <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* hw/rtl/ppmfe_frame_seq.sv */
// phase counter and channel store: classifies each compare event
module ppmfe_frame_seq #(
    parameter int CHANNELS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic                                op,
    input  logic [ppmfe_pkg::IDX_W-1:0]         channel_index,
    input  logic signed [ppmfe_pkg::VAL_W-1:0]  channel_value,
    output ppmfe_pkg::ev_t                      ev
);
    import ppmfe_pkg::*;

    localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(2 * CHANNELS + 1);

    logic signed [VAL_W-1:0] store_reg [STORE_DEPTH];
    logic [PHASE_W-1:0]      phase_reg;
    logic [PHASE_W-1:0]      phase_next;
    logic [PHASE_W-1:0]      ph;
    logic [PHASE_W-2:0]      slot_wide;
    logic [IDX_W-1:0]        slot;

    // an out-of-range count is read as the last phase
    assign ph = (phase_reg > LAST_PHASE) ? LAST_PHASE : phase_reg;
    assign slot_wide = ph[PHASE_W-1:1] - (PHASE_W-1)'(1);
    assign slot = slot_wide[IDX_W-1:0];
    assign phase_next = (ph >= LAST_PHASE) ? '0 : ph + PHASE_W'(1);

    always_comb
    begin
        ev.ctl.phase = ph;
        ev.value     = store_reg[slot];
        priority if (ph == '0)
            ev.ctl.kind = KIND_FRAME;
        else if (ph[0])
            ev.ctl.kind = KIND_SYNC;
        else
            ev.ctl.kind = KIND_CHAN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            for (int i = 0; i < STORE_DEPTH; i++)
                store_reg[i] <= '0;
        end
        else if (accept)
        begin
            if (op)
                store_reg[channel_index] <= channel_value;
            else
                phase_reg <= phase_next;
        end
    end

endmodule

/* hw/rtl/ppmfe_pulse_calc.sv */
// interval pipeline: scale, divide by full scale, offset, saturate
module ppmfe_pulse_calc #(
    parameter int FULL_SCALE   = 10000,
    parameter int TICKS_PER_US = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ppmfe_pkg::ev_t                      ev,
    input  ppmfe_pkg::cfg_t                     cfg,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ppmfe_pkg::TICK_W-1:0]        interval_ticks,
    output logic                                frame_start,
    output logic                                idle_level,
    output logic [ppmfe_pkg::PHASE_W-1:0]       phase
);
    import ppmfe_pkg::*;

    localparam int NST = 6;
    localparam int RECIP_W = PROD_W + 1;
    localparam int MUL_W = PROD_W + RECIP_W;
    // floor(2^24 / full scale): one correction step restores the exact quotient
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << PROD_W) / FULL_SCALE);
    localparam logic [PROD_W-1:0]  FS_C  = PROD_W'(FULL_SCALE);

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;

    // stage payloads
    ctl_t                    ctl0_reg, ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;
    logic signed [VAL_W-1:0] v0_reg;
    logic                    neg1_reg, neg2_reg, neg3_reg;
    logic [PROD_W-1:0]       prod1_reg, prod2_reg, prod3_reg;
    logic [PROD_W-1:0]       q0_2_reg, q0_3_reg, q0fs3_reg;
    logic signed [PROD_W:0]  qs4_reg;
    logic [TICK_W-1:0]       ticks5_reg;
    logic                    fstart5_reg;
    logic                    level5_reg;
    logic [PHASE_W-1:0]      phase5_reg;

    // combinational terms between stages
    logic [VAL_W-1:0]        mag;
    logic [PROD_W-1:0]       scale_x, mag_x, prod;
    logic [MUL_W-1:0]        prod_r;
    logic [2*PROD_W-1:0]     q0fs_full;
    logic [PROD_W-1:0]       rem, q;
    logic [PROD_W:0]         q_x;
    logic signed [US_W-1:0]  us;
    logic signed [US_W:0]    ticks_s;
    logic [TICK_W-1:0]       ticks_sat;
    logic                    fstart;

    // a stage takes new data when it is empty or its successor moves on
    always_comb
    begin
        rdy[NST] = out_ready;
        for (int k = NST - 1; k >= 0; k--)
            rdy[k] = !vld_reg[k] || rdy[k+1];
    end

    assign in_ready = rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (rdy[0])
                vld_reg[0] <= in_valid;
            for (int k = 1; k < NST; k++)
            begin
                if (rdy[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    assign mag     = v0_reg[VAL_W-1] ? VAL_W'(-v0_reg) : VAL_W'(v0_reg);
    assign scale_x = PROD_W'(cfg.pulse_scale_us);
    assign mag_x   = PROD_W'(mag);
    assign prod    = PROD_W'(scale_x * mag_x);

    assign prod_r  = MUL_W'(prod1_reg) * MUL_W'(RECIP);

    assign q0fs_full = (2*PROD_W)'(q0_2_reg) * (2*PROD_W)'(FS_C);

    assign rem = prod3_reg - q0fs3_reg;
    assign q   = q0_3_reg + ((rem >= FS_C) ? PROD_W'(1) : PROD_W'(0));
    assign q_x = {1'b0, q};

    always_comb
    begin
        unique case (ctl4_reg.kind)
            KIND_FRAME: us = $signed(US_W'(cfg.frame_sync_us));
            KIND_SYNC:  us = $signed(US_W'(cfg.channel_sync_us));
            KIND_CHAN:  us = US_W'(qs4_reg) + $signed(US_W'(cfg.centre_width_us))
                             - $signed(US_W'(cfg.channel_sync_us));
            default:    us = '0;
        endcase
        ticks_s = $signed((US_W+1)'(us)) * $signed((US_W+1)'(TICKS_PER_US));
        if (ticks_s < 0)
            ticks_sat = '0;
        else if (ticks_s > $signed((US_W+1)'(65535)))
            ticks_sat = '1;
        else
            ticks_sat = ticks_s[TICK_W-1:0];
        fstart = (ctl4_reg.kind == KIND_FRAME);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            ctl0_reg <= ev.ctl;
            v0_reg   <= ev.value;
        end
        if (rdy[1])
        begin
            ctl1_reg  <= ctl0_reg;
            neg1_reg  <= v0_reg[VAL_W-1];
            prod1_reg <= prod;
        end
        if (rdy[2])
        begin
            ctl2_reg  <= ctl1_reg;
            neg2_reg  <= neg1_reg;
            prod2_reg <= prod1_reg;
            q0_2_reg  <= prod_r[MUL_W-2:PROD_W];
        end
        if (rdy[3])
        begin
            ctl3_reg  <= ctl2_reg;
            neg3_reg  <= neg2_reg;
            prod3_reg <= prod2_reg;
            q0_3_reg  <= q0_2_reg;
            q0fs3_reg <= q0fs_full[PROD_W-1:0];
        end
        if (rdy[4])
        begin
            ctl4_reg <= ctl3_reg;
            qs4_reg  <= neg3_reg ? $signed(-q_x) : $signed(q_x);
        end
        if (rdy[5])
        begin
            ticks5_reg  <= ticks_sat;
            fstart5_reg <= fstart;
            level5_reg  <= fstart && cfg.idle_high;
            phase5_reg  <= ctl4_reg.phase;
        end
    end

    assign out_valid      = vld_reg[NST-1];
    assign interval_ticks = ticks5_reg;
    assign frame_start    = fstart5_reg;
    assign idle_level     = level5_reg;
    assign phase          = phase5_reg;

endmodule

/* hw/rtl/ppm_frame_encoder_unit.sv */
// top level of the ppm frame encoder
//
// channel  direction  handshake             payload
// in       input      in_valid / in_ready   op, channel_index, channel_value
// out      output     out_valid / out_ready interval_ticks, frame_start, idle_level, phase
// cfg      input      cfg_we                cfg_index, cfg_wdata
//
// one item per cycle unless a stalled output backs up every stage; a compare
// event's interval passes through six register stages, the first loading at
// acceptance, which hold the scale multiply, the reciprocal divide (two
// multiplies and a correction) and the saturating offset stage
// channel writes take effect at the accepting edge and produce no result
// reset clears the phase counter, the channel store and the pipeline valids
// a stalled output only holds back stages that are full; empty stages still
// take new items
module ppm_frame_encoder_unit #(
    parameter int CHANNELS     = 8,
    parameter int FULL_SCALE   = 10000,
    parameter int TICKS_PER_US = 2
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input items
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                op,
    input  logic [ppmfe_pkg::IDX_W-1:0]         channel_index,
    input  logic signed [ppmfe_pkg::VAL_W-1:0]  channel_value,
    // result items
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ppmfe_pkg::TICK_W-1:0]        interval_ticks,
    output logic                                frame_start,
    output logic                                idle_level,
    output logic [ppmfe_pkg::PHASE_W-1:0]       phase,
    // configuration writes
    input  logic                                cfg_we,
    input  logic [ppmfe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppmfe_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
    import ppmfe_pkg::*;

    cfg_t cfg;
    ev_t  ev;
    logic accept;
    logic calc_valid;

    assign accept     = in_valid && in_ready;
    // only compare events enter the interval pipeline
    assign calc_valid = accept && !op;

    ppmfe_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // phase counter and store update on the accepting edge, in item order
    ppmfe_frame_seq #(
        .CHANNELS (CHANNELS)
    ) u_frame_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .op            (op),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .ev            (ev)
    );

    // in_ready depends only on pipeline occupancy and out_ready, never on op
    ppmfe_pulse_calc #(
        .FULL_SCALE   (FULL_SCALE),
        .TICKS_PER_US (TICKS_PER_US)
    ) u_pulse_calc (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (calc_valid),
        .in_ready       (in_ready),
        .ev             (ev),
        .cfg            (cfg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .interval_ticks (interval_ticks),
        .frame_start    (frame_start),
        .idle_level     (idle_level),
        .phase          (phase)
    );

endmodule

/* hw/rtl/ppmfe_checker.sv */
// port-level checker of the ppm frame encoder and its bind
module ppmfe_checker #(
    parameter int CHANNELS = 8
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic [ppmfe_pkg::TICK_W-1:0]        interval_ticks,
    input logic                                frame_start,
    input logic                                idle_level,
    input logic [ppmfe_pkg::PHASE_W-1:0]       phase
);
    import ppmfe_pkg::*;

    localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(2 * CHANNELS + 1);

    logic               seen_reg;
    logic [PHASE_W-1:0] last_phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            last_phase_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            seen_reg       <= 1'b1;
            last_phase_reg <= phase;
        end
    end

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(interval_ticks)
            && $stable(phase) && $stable(frame_start) && $stable(idle_level))
        else $error("result changed while stalled");

    a_frame_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_start == (phase == '0))
        else $error("frame start does not match phase zero");

    a_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_start |-> !idle_level)
        else $error("idle level outside frame start");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> phase <= LAST_PHASE)
        else $error("phase beyond last phase");

    // consecutive results walk the frame one phase at a time
    a_phase_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_reg |->
            (phase == last_phase_reg + PHASE_W'(1))
            || (last_phase_reg == LAST_PHASE && phase == '0))
        else $error("phase sequence broken");

endmodule

bind ppm_frame_encoder_unit ppmfe_checker #(
    .CHANNELS (CHANNELS)
) u_ppmfe_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .interval_ticks (interval_ticks),
    .frame_start    (frame_start),
    .idle_level     (idle_level),
    .phase          (phase)
);
